// File: src/dual_free_list_chunk_allocator_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the dual free-list chunk allocator
// Concurrent checks that compile away when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef DUAL_FREE_LIST_CHUNK_ALLOCATOR_MACROS_SVH
`define DUAL_FREE_LIST_CHUNK_ALLOCATOR_MACROS_SVH

`ifndef SYNTH

// Check that a implies b in the same cycle.
`define DFL_ASSERT_NOW(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("assertion failed: same-cycle implication");

// Check that a implies b in the following cycle.
`define DFL_ASSERT_NEXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("assertion failed: next-cycle implication");

`else

`define DFL_ASSERT_NOW(label, clk, rst, a, b)
`define DFL_ASSERT_NEXT(label, clk, rst, a, b)

`endif

`endif

// File: src/dfl_pkg.sv
// ----------------------------------------------------------------------------
// dfl_pkg
// Shared constants and types of the dual free-list chunk allocator.
// ----------------------------------------------------------------------------
package dfl_pkg;

  localparam int CHUNK_COUNT = 1024;
  localparam int ADDR_W      = (CHUNK_COUNT > 1) ? $clog2(CHUNK_COUNT) : 1;
  localparam int IDX_W       = 10;
  localparam int LINK_W      = ADDR_W + 1;

  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(CHUNK_COUNT - 1);

  localparam logic [2:0] OP_TENSOR_ALLOC = 3'd0;
  localparam logic [2:0] OP_TENSOR_FREE  = 3'd1;
  localparam logic [2:0] OP_DATA_ALLOC   = 3'd2;
  localparam logic [2:0] OP_DATA_ZALLOC  = 3'd3;
  localparam logic [2:0] OP_DATA_FREE    = 3'd4;

  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_EMPTY     = 2'd1;
  localparam logic [1:0] STAT_NULL_FREE = 2'd2;
  localparam logic [1:0] STAT_RANGE     = 2'd3;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_POP
  } state_t;

  // Commands from the sequencer to one list.
  typedef struct packed {
    logic              clear;
    logic [ADDR_W-1:0] clear_addr;
    logic              push;
    logic [ADDR_W-1:0] push_idx;
    logic              pop_rd;
    logic              pop_commit;
  } list_cmd_t;

  // Head of one list, seen by the sequencer.
  typedef struct packed {
    logic              head_valid;
    logic [ADDR_W-1:0] head_idx;
  } list_head_t;

endpackage

// File: src/dfl_list.sv
// ----------------------------------------------------------------------------
// dfl_list
// One LIFO free list: a next-link memory with a registered read and a head.
// ----------------------------------------------------------------------------
module dfl_list (
  input  logic               clk,
  input  logic               rst,
  input  dfl_pkg::list_cmd_t cmd,
  output dfl_pkg::list_head_t head
);
  import dfl_pkg::*;

  logic [LINK_W-1:0] mem [CHUNK_COUNT];
  logic [LINK_W-1:0] rd_data;
  logic              head_valid;
  logic [ADDR_W-1:0] head_idx;

  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [LINK_W-1:0] wr_data;
  logic              clear_last;

  // Initial chain: entry i links to i+1, the last entry is null.
  assign clear_last = (cmd.clear_addr == LAST_ADDR);

  always_comb begin
    wr_en   = cmd.clear | cmd.push;
    wr_addr = cmd.push_idx;
    wr_data = {head_valid, head_idx};
    if (cmd.clear) begin
      wr_addr = cmd.clear_addr;
      wr_data = {!clear_last, clear_last ? '0 : cmd.clear_addr + 1'b1};
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.pop_rd) begin
      rd_data <= mem[head_idx];
    end
  end

  // Advance the head on push and on a completed pop.
  always_ff @(posedge clk) begin
    if (rst) begin
      head_valid <= 1'b1;
      head_idx   <= '0;
    end else if (cmd.push) begin
      head_valid <= 1'b1;
      head_idx   <= cmd.push_idx;
    end else if (cmd.pop_commit) begin
      head_valid <= rd_data[LINK_W-1];
      head_idx   <= rd_data[ADDR_W-1:0];
    end
  end

  assign head.head_valid = head_valid;
  assign head.head_idx   = head_idx;

endmodule

// File: src/dual_free_list_chunk_allocator.sv
// ----------------------------------------------------------------------------
// dual_free_list_chunk_allocator
// Two LIFO free lists of chunk indices (tensor headers, data chunks).
// ----------------------------------------------------------------------------
//
//  channel   handshake            payload
//  -------   ------------------   --------------------------------------------
//  request   start & !busy        opcode, chunk_index, index_present
//  result    done (one cycle)     granted_index, granted, clear_needed, status
//
//  A free, a rejected request or an unused opcode shows its result in the cycle
//  after the transfer, and a new request may follow at once. A granted
//  allocation first reads the head's next link from the list memory into a
//  register, then passes through S_POP, which registers its result; busy is
//  high in S_POP. After reset a clearing pass rebuilds both chains entry by
//  entry, with busy high. Results cannot be stalled by the receiver.
// ----------------------------------------------------------------------------
`include "dual_free_list_chunk_allocator_macros.svh"

module dual_free_list_chunk_allocator (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  output logic                     busy,
  input  logic [2:0]               opcode,
  input  logic [dfl_pkg::IDX_W-1:0] chunk_index,
  input  logic                     index_present,
  output logic                     done,
  output logic [dfl_pkg::IDX_W-1:0] granted_index,
  output logic                     granted,
  output logic                     clear_needed,
  output logic [1:0]               status
);
  import dfl_pkg::*;

  state_t            state, state_next;
  logic [ADDR_W-1:0] clr_addr, clr_addr_next;
  logic              pop_data, pop_data_next;   // pop in flight is on the data list
  logic              pop_zero, pop_zero_next;

  logic              done_next;
  logic [IDX_W-1:0]  granted_index_next;
  logic              granted_next;
  logic              clear_needed_next;
  logic [1:0]        status_next;

  list_cmd_t         hdr_cmd, dat_cmd;
  list_head_t        hdr_head, dat_head;
  list_head_t        sel_head;
  logic              accept;
  logic              idx_in_range;

  dfl_list u_hdr_list (
    .clk  (clk),
    .rst  (rst),
    .cmd  (hdr_cmd),
    .head (hdr_head)
  );

  dfl_list u_dat_list (
    .clk  (clk),
    .rst  (rst),
    .cmd  (dat_cmd),
    .head (dat_head)
  );

  assign busy         = (state != S_IDLE);
  assign accept       = start && !busy;
  assign idx_in_range = (32'(chunk_index) < CHUNK_COUNT);

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr_addr <= '0;
      done     <= 1'b0;
    end else begin
      state    <= state_next;
      clr_addr <= clr_addr_next;
      done     <= done_next;
    end
  end

  // Result payload and pop context need no reset; done qualifies them.
  always_ff @(posedge clk) begin
    pop_data      <= pop_data_next;
    pop_zero      <= pop_zero_next;
    granted_index <= granted_index_next;
    granted       <= granted_next;
    clear_needed  <= clear_needed_next;
    status        <= status_next;
  end

  always_comb begin
    state_next         = state;
    clr_addr_next      = clr_addr;
    pop_data_next      = pop_data;
    pop_zero_next      = pop_zero;
    done_next          = 1'b0;
    granted_index_next = '0;
    granted_next       = 1'b0;
    clear_needed_next  = 1'b0;
    status_next        = STAT_OK;
    hdr_cmd            = '0;
    dat_cmd            = '0;
    sel_head           = pop_data ? dat_head : hdr_head;

    case (state)
      S_CLEAR: begin
        // Rebuild entry clr_addr of both lists, one entry per cycle.
        hdr_cmd.clear      = 1'b1;
        hdr_cmd.clear_addr = clr_addr;
        dat_cmd.clear      = 1'b1;
        dat_cmd.clear_addr = clr_addr;
        clr_addr_next      = clr_addr + 1'b1;
        if (clr_addr == LAST_ADDR) begin
          state_next = S_IDLE;
        end
      end

      S_IDLE: begin
        if (accept) begin
          done_next = 1'b1;
          case (opcode)
            OP_TENSOR_ALLOC, OP_DATA_ALLOC, OP_DATA_ZALLOC: begin
              pop_data_next = (opcode != OP_TENSOR_ALLOC);
              pop_zero_next = (opcode == OP_DATA_ZALLOC);
              sel_head      = (opcode == OP_TENSOR_ALLOC) ? hdr_head : dat_head;
              if (sel_head.head_valid) begin
                // Read the head's link now; finish the pop next cycle.
                done_next  = 1'b0;
                state_next = S_POP;
                if (opcode == OP_TENSOR_ALLOC) begin
                  hdr_cmd.pop_rd = 1'b1;
                end else begin
                  dat_cmd.pop_rd = 1'b1;
                end
              end else begin
                status_next = STAT_EMPTY;
              end
            end
            OP_TENSOR_FREE, OP_DATA_FREE: begin
              if (!index_present) begin
                status_next = STAT_NULL_FREE;
              end else if (!idx_in_range) begin
                status_next = STAT_RANGE;
              end else if (opcode == OP_TENSOR_FREE) begin
                hdr_cmd.push     = 1'b1;
                hdr_cmd.push_idx = ADDR_W'(chunk_index);
              end else begin
                dat_cmd.push     = 1'b1;
                dat_cmd.push_idx = ADDR_W'(chunk_index);
              end
            end
            default: begin
              // Unused opcode: report all-zero result, touch nothing.
            end
          endcase
        end
      end

      S_POP: begin
        // Hand out the old head and advance to its link.
        hdr_cmd.pop_commit = !pop_data;
        dat_cmd.pop_commit = pop_data;
        done_next          = 1'b1;
        granted_next       = 1'b1;
        granted_index_next = IDX_W'(sel_head.head_idx);
        clear_needed_next  = pop_zero;
        state_next         = S_IDLE;
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // A granted tensor-header pop always passes through S_POP.
  `DFL_ASSERT_NEXT(a_pop_busy, clk, rst, accept && (opcode == OP_TENSOR_ALLOC) && hdr_head.head_valid, state == S_POP)
  // The pop cycle always yields a granted result.
  `DFL_ASSERT_NEXT(a_pop_grants, clk, rst, state == S_POP, done && granted && (status == STAT_OK))
  // A clear request only comes with a granted chunk.
  `DFL_ASSERT_NOW(a_clear_granted, clk, rst, done && clear_needed, granted && (status == STAT_OK))
  // No result is shown while the block is busy.
  `DFL_ASSERT_NOW(a_done_idle, clk, rst, done, state == S_IDLE)

endmodule
